[rtl/acu_pkg.sv]
// Shared types and codes for the ALU and condition-code unit.
`default_nettype none

package acu_pkg;

	typedef enum logic [3:0] {
		MODE_MOVE = 4'd0,
		MODE_ADD  = 4'd1,
		MODE_SUB  = 4'd2,
		MODE_CMP  = 4'd3,
		MODE_AND  = 4'd4,
		MODE_OR   = 4'd5,
		MODE_ROR  = 4'd6,
		MODE_LSR  = 4'd7,
		MODE_BTST = 4'd8,
		MODE_BCLR = 4'd9,
		MODE_BCC  = 4'd10,
		MODE_DBCC = 4'd11,
		MODE_ADDA = 4'd12,
		MODE_ADDQ = 4'd13,
		MODE_SUBQ = 4'd14
	} mode_t;

	typedef enum logic [1:0] {
		SIZE_BYTE = 2'd0,
		SIZE_WORD = 2'd1,
		SIZE_LONG = 2'd2
	} opsize_t;

	typedef enum logic [3:0] {
		CC_T  = 4'd0,
		CC_F  = 4'd1,
		CC_HI = 4'd2,
		CC_LS = 4'd3,
		CC_CC = 4'd4,
		CC_CS = 4'd5,
		CC_NE = 4'd6,
		CC_EQ = 4'd7,
		CC_VC = 4'd8,
		CC_VS = 4'd9,
		CC_PL = 4'd10,
		CC_MI = 4'd11,
		CC_GE = 4'd12,
		CC_LT = 4'd13,
		CC_GT = 4'd14,
		CC_LE = 4'd15
	} cond_t;

	localparam int unsigned FLAG_X = 4;
	localparam int unsigned FLAG_N = 3;
	localparam int unsigned FLAG_Z = 2;
	localparam int unsigned FLAG_V = 1;
	localparam int unsigned FLAG_C = 0;

	localparam int unsigned IN_DATA_W  = 80;
	localparam int unsigned IN_USER_W  = 6;
	localparam int unsigned OUT_DATA_W = 40;

	// One operation as held in the input register.
	typedef struct packed {
		logic [3:0]  mode;
		logic [1:0]  size;
		logic [31:0] dest_value;
		logic [31:0] src_value;
		logic [4:0]  flags_in;
		logic [3:0]  cond_code;
	} op_t;

	// One result as held in the output register.
	typedef struct packed {
		logic [31:0] result;
		logic [4:0]  flags_out;
		logic        cond_true;
		logic        branch_taken;
	} res_t;

endpackage

`default_nettype wire

[rtl/cpu_alu_condition_code_unit.sv]
// Top level: 68000-style integer ALU with condition-code and branch evaluation.
`default_nettype none

// Channel  Dir  tdata                                         tuser
// s_axis   in   dest_value, src_value, flags_in, cond_code   mode, size
// m_axis   out  result, flags_out, cond_true, branch_taken   -
//
// One beat per cycle sustained while m_axis is ready; a beat passes the input
// register, then the result register. The path between them is one 33-bit add
// or subtract plus flag and merge selection, which sets the clock.
// Reset clears both stage valid bits; payload registers are not reset.
// A stall on m_axis holds the result stage; the input stage still takes a
// beat while it is empty, so one beat can wait behind a stalled result.

module cpu_alu_condition_code_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// [31:0] dest_value, [63:32] src_value, [68:64] flags_in, [72:69] cond_code, rest zero
	input  wire logic [acu_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// [3:0] mode, [5:4] size
	input  wire logic [acu_pkg::IN_USER_W-1:0]      s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// [31:0] result, [36:32] flags_out, [37] cond_true, [38] branch_taken, rest zero
	output logic [acu_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);
	import acu_pkg::*;

	op_t  op_s1;
	logic valid_s1;
	res_t res_s2;
	logic valid_s2;
	res_t res_d;
	logic adv_s2;
	logic adv_s1;

	// Result stage moves when empty or drained; input stage moves when empty or
	// when the result stage can take its beat.
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			op_s1.mode       <= s_axis_tuser[3:0];
			op_s1.size       <= s_axis_tuser[5:4];
			op_s1.dest_value <= s_axis_tdata[31:0];
			op_s1.src_value  <= s_axis_tdata[63:32];
			op_s1.flags_in   <= s_axis_tdata[68:64];
			op_s1.cond_code  <= s_axis_tdata[72:69];
		end
	end

	// ---------------- execute ----------------
	logic [1:0]  sz;
	logic [31:0] dst;
	logic [31:0] src;
	logic [4:0]  fin;
	logic [31:0] mask;
	logic        ct;
	logic        fc, fv, fz, fn;
	logic [31:0] opb;
	logic [32:0] sum_w;
	logic [32:0] dif_w;
	logic [31:0] logic_v;
	logic [31:0] rot_w;
	logic [15:0] rot_v;
	logic [16:0] shr_w;
	logic [4:0]  bit_no;
	logic        tbit;
	logic [15:0] dec_v;
	logic [31:0] adda_src;
	logic        add_c, sub_c, add_o, sub_o;

	// Sign bit of a value at the operand size.
	function automatic logic sign_of(input logic [31:0] v, input logic [1:0] s);
		logic r;
		unique case (s)
			SIZE_BYTE: r = v[7];
			SIZE_WORD: r = v[15];
			default:   r = v[31];
		endcase
		return r;
	endfunction

	assign sz   = (op_s1.size == 2'd3) ? SIZE_LONG : op_s1.size;
	assign dst  = op_s1.dest_value;
	assign src  = op_s1.src_value;
	assign fin  = op_s1.flags_in;
	assign mask = (sz == SIZE_BYTE) ? 32'h0000_00FF :
	              (sz == SIZE_WORD) ? 32'h0000_FFFF : 32'hFFFF_FFFF;

	assign fc = fin[FLAG_C];
	assign fv = fin[FLAG_V];
	assign fz = fin[FLAG_Z];
	assign fn = fin[FLAG_N];

	always_comb begin
		case (cond_t'(op_s1.cond_code))
			CC_T:    ct = 1'b1;
			CC_F:    ct = 1'b0;
			CC_HI:   ct = !fc && !fz;
			CC_LS:   ct = fc || fz;
			CC_CC:   ct = !fc;
			CC_CS:   ct = fc;
			CC_NE:   ct = !fz;
			CC_EQ:   ct = fz;
			CC_VC:   ct = !fv;
			CC_VS:   ct = fv;
			CC_PL:   ct = !fn;
			CC_MI:   ct = fn;
			CC_GE:   ct = fn == fv;
			CC_LT:   ct = fn != fv;
			CC_GT:   ct = !fz && (fn == fv);
			default: ct = fz || (fn != fv);
		endcase
	end

	// Quick forms take a 3-bit immediate where zero stands for eight.
	always_comb begin
		if (op_s1.mode == MODE_ADDQ || op_s1.mode == MODE_SUBQ) begin
			opb = (src[2:0] == 3'd0) ? 32'd8 : {29'd0, src[2:0]};
		end else begin
			opb = src;
		end
	end

	assign sum_w = {1'b0, dst} + {1'b0, opb};
	assign dif_w = {1'b0, dst} - {1'b0, opb};

	// Carry or borrow out of the sized operand, recovered from the carry into
	// the next bit of the full-width sum.
	always_comb begin
		unique case (sz)
			SIZE_BYTE: begin
				add_c = sum_w[8] ^ dst[8] ^ opb[8];
				sub_c = dif_w[8] ^ dst[8] ^ opb[8];
			end
			SIZE_WORD: begin
				add_c = sum_w[16] ^ dst[16] ^ opb[16];
				sub_c = dif_w[16] ^ dst[16] ^ opb[16];
			end
			default: begin
				add_c = sum_w[32];
				sub_c = dif_w[32];
			end
		endcase
	end

	assign add_o = sign_of(~(dst ^ opb) & (dst ^ sum_w[31:0]), sz);
	assign sub_o = sign_of((dst ^ opb) & (dst ^ dif_w[31:0]), sz);

	assign logic_v = (op_s1.mode == MODE_AND) ? (dst & src) : (dst | src);

	// Word rotate: shift a doubled copy, keep the low half.
	assign rot_w = {dst[15:0], dst[15:0]} >> src[3:0];
	assign rot_v = rot_w[15:0];

	// Word shift: a guard bit below the word catches the last bit out.
	assign shr_w = {dst[15:0], 1'b0} >> src[5:0];

	assign bit_no = (sz == SIZE_BYTE) ? {2'b00, src[2:0]} : src[4:0];
	assign tbit   = dst[bit_no];

	assign dec_v    = dst[15:0] - 16'd1;
	assign adda_src = (sz == SIZE_LONG) ? src : {{16{src[15]}}, src[15:0]};

	always_comb begin
		res_d.result       = dst;
		res_d.flags_out    = fin;
		res_d.cond_true    = ct;
		res_d.branch_taken = 1'b0;
		unique case (op_s1.mode)
			MODE_MOVE: begin
				res_d.result    = (dst & ~mask) | (src & mask);
				res_d.flags_out = {fin[FLAG_X], sign_of(src, sz), (src & mask) == 32'd0,
				                   1'b0, 1'b0};
			end
			MODE_ADD, MODE_ADDQ: begin
				res_d.result    = (dst & ~mask) | (sum_w[31:0] & mask);
				res_d.flags_out = {add_c, sign_of(sum_w[31:0], sz),
				                   (sum_w[31:0] & mask) == 32'd0, add_o, add_c};
			end
			MODE_SUB, MODE_SUBQ: begin
				res_d.result    = (dst & ~mask) | (dif_w[31:0] & mask);
				res_d.flags_out = {sub_c, sign_of(dif_w[31:0], sz),
				                   (dif_w[31:0] & mask) == 32'd0, sub_o, sub_c};
			end
			MODE_CMP: begin
				res_d.flags_out = {fin[FLAG_X], sign_of(dif_w[31:0], sz),
				                   (dif_w[31:0] & mask) == 32'd0, sub_o, sub_c};
			end
			MODE_AND, MODE_OR: begin
				res_d.result    = (dst & ~mask) | (logic_v & mask);
				res_d.flags_out = {fin[FLAG_X], sign_of(logic_v, sz),
				                   (logic_v & mask) == 32'd0, 1'b0, 1'b0};
			end
			MODE_ROR: begin
				res_d.result    = {dst[31:16], rot_v};
				res_d.flags_out = {fin[FLAG_X], rot_v[15], rot_v == 16'd0, 1'b0,
				                   (src[5:0] != 6'd0) && rot_v[15]};
			end
			MODE_LSR: begin
				res_d.result    = {dst[31:16], shr_w[16:1]};
				res_d.flags_out = {(src[5:0] == 6'd0) ? fin[FLAG_X] : shr_w[0],
				                   shr_w[16], shr_w[16:1] == 16'd0, 1'b0, shr_w[0]};
			end
			MODE_BTST: begin
				res_d.flags_out[FLAG_Z] = !tbit;
			end
			MODE_BCLR: begin
				res_d.flags_out[FLAG_Z] = !tbit;
				res_d.result            = dst & ~(32'd1 << bit_no);
			end
			MODE_BCC: begin
				res_d.branch_taken = ct;
			end
			MODE_DBCC: begin
				// Decrement only when the condition fails; stop at minus one.
				if (!ct) begin
					res_d.result       = {dst[31:16], dec_v};
					res_d.branch_taken = dec_v != 16'hFFFF;
				end
			end
			MODE_ADDA: begin
				res_d.result = dst + adda_src;
			end
			default: begin
				// Unused code: pass the destination through, flags untouched.
			end
		endcase
	end

	// ---------------- result stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, res_s2.branch_taken, res_s2.cond_true,
	                        res_s2.flags_out, res_s2.result};

endmodule

`default_nettype wire

[sim/cpu_alu_condition_code_unit_tb.sv]
// Self-checking testbench for the ALU and condition-code unit: directed table, then random beats.
module cpu_alu_condition_code_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import acu_pkg::*;

	// Codes outside the enums that the unit still has to handle.
	localparam logic [3:0] MODE_SPARE = 4'd15;
	localparam logic [1:0] SIZE_SPARE = 2'd3;

	localparam logic [31:0] WORD_MASK = 32'h0000FFFF;
	localparam logic [31:0] WORD_SIGN = 32'h00008000;

	localparam int RANDOM_OPS   = 1350;
	localparam int CALM_FIRST   = 700;  // no idling on either side from here...
	localparam int CALM_LAST    = 1000; // ...up to here
	localparam int HOLD_AFTER   = 400;  // accepted beats before the long output stall
	localparam int HOLD_CYCLES  = 40;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	// One directed beat; the expected fields count only where known is set.
	typedef struct packed {
		logic [3:0]  mode;
		logic [1:0]  size;
		logic [31:0] dest;
		logic [31:0] src;
		logic [4:0]  fl;
		logic [3:0]  cc;
		logic        known;
		logic [31:0] x_res;
		logic [4:0]  x_fl;
		logic        x_ct;
		logic        x_tk;
	} stim_row_t;

	localparam int OPENING_N = 27;

	// Every operation, count and size extremes, quick immediate of zero, the unused
	// size and mode codes, and dbcc both with the condition false and true.
	stim_row_t opening_ops [OPENING_N] = '{
		'{MODE_MOVE, SIZE_BYTE, 32'hFFFFFFFF, 32'h00000080, 5'h1F, CC_T,  1'b1,
			32'hFFFFFF80, 5'h18, 1'b1, 1'b0},
		'{MODE_MOVE, SIZE_LONG, 32'h12345678, 32'h00000000, 5'h00, CC_F,  1'b1,
			32'h00000000, 5'h04, 1'b0, 1'b0},
		'{MODE_ADD,  SIZE_BYTE, 32'h000000FF, 32'h00000001, 5'h00, CC_T,  1'b1,
			32'h00000000, 5'h15, 1'b1, 1'b0},
		'{MODE_ADD,  SIZE_LONG, 32'h7FFFFFFF, 32'h00000001, 5'h10, CC_T,  1'b1,
			32'h80000000, 5'h0A, 1'b1, 1'b0},
		'{MODE_ADD,  SIZE_SPARE, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'h00, CC_HI, 1'b0,
			32'h0, 5'h0, 1'b0, 1'b0},
		'{MODE_SUB,  SIZE_WORD, 32'hABCD0000, 32'h00000001, 5'h00, CC_HI, 1'b1,
			32'hABCDFFFF, 5'h19, 1'b1, 1'b0},
		'{MODE_CMP,  SIZE_LONG, 32'h80000000, 32'h00000001, 5'h10, CC_LS, 1'b1,
			32'h80000000, 5'h12, 1'b0, 1'b0},
		'{MODE_AND,  SIZE_WORD, 32'h1234F0F0, 32'h00000F0F, 5'h1F, CC_CC, 1'b1,
			32'h12340000, 5'h14, 1'b0, 1'b0},
		'{MODE_OR,   SIZE_BYTE, 32'h00000000, 32'h00000080, 5'h00, CC_CS, 1'b1,
			32'h00000080, 5'h08, 1'b0, 1'b0},
		'{MODE_ROR,  SIZE_WORD, 32'h00018001, 32'h00000040, 5'h11, CC_NE, 1'b1,
			32'h00018001, 5'h18, 1'b1, 1'b0},
		'{MODE_ROR,  SIZE_LONG, 32'h00000001, 32'h00000001, 5'h00, CC_EQ, 1'b1,
			32'h00008000, 5'h09, 1'b0, 1'b0},
		'{MODE_ROR,  SIZE_BYTE, 32'hFFFF8000, 32'h00000010, 5'h00, CC_VC, 1'b1,
			32'hFFFF8000, 5'h09, 1'b1, 1'b0},
		'{MODE_LSR,  SIZE_WORD, 32'h00008000, 32'h00000000, 5'h1F, CC_VS, 1'b1,
			32'h00008000, 5'h18, 1'b1, 1'b0},
		'{MODE_LSR,  SIZE_WORD, 32'h00000001, 32'h00000001, 5'h00, CC_PL, 1'b1,
			32'h00000000, 5'h15, 1'b1, 1'b0},
		'{MODE_LSR,  SIZE_LONG, 32'hAAAA8000, 32'h00000010, 5'h00, CC_MI, 1'b1,
			32'hAAAA0000, 5'h15, 1'b0, 1'b0},
		'{MODE_LSR,  SIZE_BYTE, 32'h0000FFFF, 32'h00000011, 5'h1F, CC_GE, 1'b1,
			32'h00000000, 5'h04, 1'b1, 1'b0},
		'{MODE_LSR,  SIZE_WORD, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'h1F, CC_LT, 1'b0,
			32'h0, 5'h0, 1'b0, 1'b0},
		'{MODE_BTST, SIZE_BYTE, 32'h00000100, 32'h00000008, 5'h1B, CC_LT, 1'b1,
			32'h00000100, 5'h1F, 1'b0, 1'b0},
		'{MODE_BTST, SIZE_LONG, 32'h80000000, 32'h0000001F, 5'h04, CC_GT, 1'b1,
			32'h80000000, 5'h00, 1'b0, 1'b0},
		'{MODE_BCLR, SIZE_LONG, 32'hFFFFFFFF, 32'h0000001F, 5'h1F, CC_LE, 1'b1,
			32'h7FFFFFFF, 5'h1B, 1'b1, 1'b0},
		'{MODE_BCC,  SIZE_WORD, 32'h13579BDF, 32'h12345678, 5'h00, CC_HI, 1'b1,
			32'h13579BDF, 5'h00, 1'b1, 1'b1},
		'{MODE_DBCC, SIZE_WORD, 32'h12340000, 32'h00000000, 5'h0A, CC_F,  1'b1,
			32'h1234FFFF, 5'h0A, 1'b0, 1'b0},
		'{MODE_DBCC, SIZE_WORD, 32'h00000000, 32'h00000000, 5'h00, CC_T,  1'b1,
			32'h00000000, 5'h00, 1'b1, 1'b0},
		'{MODE_ADDA, SIZE_WORD, 32'h00010000, 32'h00008000, 5'h15, CC_T,  1'b1,
			32'h00008000, 5'h15, 1'b1, 1'b0},
		'{MODE_ADDQ, SIZE_LONG, 32'hFFFFFFF8, 32'h00000000, 5'h00, CC_T,  1'b1,
			32'h00000000, 5'h15, 1'b1, 1'b0},
		'{MODE_SUBQ, SIZE_BYTE, 32'h00000080, 32'h0000000F, 5'h00, CC_T,  1'b1,
			32'h00000079, 5'h02, 1'b1, 1'b0},
		'{MODE_SPARE, SIZE_LONG, 32'h2468ACE0, 32'h00000000, 5'h0E, CC_EQ, 1'b1,
			32'h2468ACE0, 5'h0E, 1'b1, 1'b0}
	};

	// Operand values near sign and carry boundaries of every size.
	localparam logic [31:0] CORNER_WORDS [8] = '{
		32'h00000000, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
		32'h0000007F, 32'h00000080, 32'h00007FFF, 32'h00008000
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [IN_USER_W-1:0]  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	res_t pending_results [$];
	int   fail_count   = 0;
	int   accepted_ops = 0;
	int   cycle_count  = 0;
	logic calm         = 1'b0;
	logic hold_off     = 1'b0;
	res_t seen_beat;
	res_t due_beat;
	res_t row_beat;
	op_t  next_op;

	cpu_alu_condition_code_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic cond_holds(logic [4:0] fl, logic [3:0] cc);
		logic c, v, z, n;
		c = fl[FLAG_C];
		v = fl[FLAG_V];
		z = fl[FLAG_Z];
		n = fl[FLAG_N];
		case (cc)
			CC_T:    return 1'b1;
			CC_F:    return 1'b0;
			CC_HI:   return !c && !z;
			CC_LS:   return c || z;
			CC_CC:   return !c;
			CC_CS:   return c;
			CC_NE:   return !z;
			CC_EQ:   return z;
			CC_VC:   return !v;
			CC_VS:   return v;
			CC_PL:   return !n;
			CC_MI:   return n;
			CC_GE:   return n == v;
			CC_LT:   return n != v;
			CC_GT:   return !z && (n == v);
			default: return z || (n != v);
		endcase
	endfunction

	// N and Z of a value at the width given by its mask and sign bit.
	function automatic logic [4:0] nz_of(logic [31:0] val, logic [31:0] mask,
			logic [31:0] sign);
		logic [4:0] f;
		f = '0;
		f[FLAG_Z] = (val & mask) == 32'd0;
		f[FLAG_N] = (val & sign) != 32'd0;
		return f;
	endfunction

	// X N Z V C of lhs plus or minus rhs, all cut to the operand width.
	function automatic logic [4:0] arith_of(logic [31:0] lhs, logic [31:0] rhs,
			logic [31:0] sum, logic [31:0] mask, logic [31:0] sign, logic is_sub);
		logic [31:0] lm, rm, sm;
		logic [32:0] total;
		logic        carry, ovf;
		logic [4:0]  f;
		lm = lhs & mask;
		rm = rhs & mask;
		sm = sum & mask;
		if (is_sub) begin
			carry = lm < rm;
			ovf   = ((lm ^ rm) & (lm ^ sm) & sign) != 32'd0;
		end else begin
			total = {1'b0, lm} + {1'b0, rm};
			carry = total > {1'b0, mask};
			ovf   = (~(lm ^ rm) & (lm ^ sm) & sign) != 32'd0;
		end
		f = nz_of(sm, mask, sign);
		f[FLAG_C] = carry;
		f[FLAG_X] = carry;
		f[FLAG_V] = ovf;
		return f;
	endfunction

	function automatic res_t alu_outcome(op_t op);
		logic [31:0] mask, sign, dest, src, val, spun;
		logic [15:0] w;
		logic [5:0]  amt;
		logic [4:0]  bitn, fin, f;
		logic        ct, taken, carry;
		res_t        out;
		dest  = op.dest_value;
		src   = op.src_value;
		fin   = op.flags_in;
		ct    = cond_holds(fin, op.cond_code);
		taken = 1'b0;
		val   = dest;
		f     = fin;
		case (op.size)
			SIZE_BYTE: begin
				mask = 32'h000000FF;
				sign = 32'h00000080;
			end
			SIZE_WORD: begin
				mask = WORD_MASK;
				sign = WORD_SIGN;
			end
			default: begin
				mask = 32'hFFFFFFFF;
				sign = 32'h80000000;
			end
		endcase
		// Quick forms carry a 3-bit immediate where zero stands for eight.
		if (op.mode == MODE_ADDQ || op.mode == MODE_SUBQ)
			src = (src[2:0] == 3'd0) ? 32'd8 : {29'd0, src[2:0]};
		case (op.mode)
			MODE_MOVE: begin
				val = (dest & ~mask) | (src & mask);
				f = nz_of(src, mask, sign);
				f[FLAG_X] = fin[FLAG_X];
			end
			MODE_ADD, MODE_ADDQ: begin
				spun = dest + src;
				val = (dest & ~mask) | (spun & mask);
				f = arith_of(dest, src, spun, mask, sign, 1'b0);
			end
			MODE_SUB, MODE_SUBQ: begin
				spun = dest - src;
				val = (dest & ~mask) | (spun & mask);
				f = arith_of(dest, src, spun, mask, sign, 1'b1);
			end
			MODE_CMP: begin
				f = arith_of(dest, src, dest - src, mask, sign, 1'b1);
				f[FLAG_X] = fin[FLAG_X];
			end
			MODE_AND, MODE_OR: begin
				spun = (op.mode == MODE_AND) ? (dest & src) : (dest | src);
				val = (dest & ~mask) | (spun & mask);
				f = nz_of(spun, mask, sign);
				f[FLAG_X] = fin[FLAG_X];
			end
			MODE_ROR: begin
				// Low half of the doubled word shifted right is the rotated word.
				amt  = src[5:0];
				spun = {dest[15:0], dest[15:0]} >> amt[3:0];
				w    = spun[15:0];
				val  = {dest[31:16], w};
				f = nz_of({16'd0, w}, WORD_MASK, WORD_SIGN);
				f[FLAG_X] = fin[FLAG_X];
				f[FLAG_C] = (amt != 6'd0) && w[15];
			end
			MODE_LSR: begin
				amt   = src[5:0];
				spun  = {16'd0, dest[15:0]} >> (amt - 6'd1);
				carry = (amt != 6'd0) && (amt <= 6'd16) && spun[0];
				w     = (amt >= 6'd16) ? 16'd0 : (dest[15:0] >> amt);
				val   = {dest[31:16], w};
				f = nz_of({16'd0, w}, WORD_MASK, WORD_SIGN);
				f[FLAG_C] = carry;
				f[FLAG_X] = (amt == 6'd0) ? fin[FLAG_X] : carry;
			end
			MODE_BTST, MODE_BCLR: begin
				bitn = (op.size == SIZE_BYTE) ? {2'b00, src[2:0]} : src[4:0];
				f[FLAG_Z] = !dest[bitn];
				if (op.mode == MODE_BCLR)
					val[bitn] = 1'b0;
			end
			MODE_BCC: begin
				taken = ct;
			end
			MODE_DBCC: begin
				// Count down only when the condition fails; stop at minus one.
				if (!ct) begin
					w = dest[15:0] - 16'd1;
					val = {dest[31:16], w};
					taken = (w != 16'hFFFF);
				end
			end
			MODE_ADDA: begin
				if (op.size == SIZE_BYTE || op.size == SIZE_WORD)
					val = dest + {{16{src[15]}}, src[15:0]};
				else
					val = dest + src;
			end
			default: begin
			end
		endcase
		out.result       = val;
		out.flags_out    = f;
		out.cond_true    = ct;
		out.branch_taken = taken;
		return out;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic logic [31:0] pick_word();
		if ($urandom_range(3) == 0)
			return CORNER_WORDS[$urandom_range(7)];
		return $urandom();
	endfunction

	function automatic op_t random_op();
		op_t op;
		op.mode       = ($urandom_range(99) == 0) ? MODE_SPARE : 4'($urandom_range(14));
		op.size       = ($urandom_range(19) == 0) ? SIZE_SPARE : 2'($urandom_range(2));
		op.dest_value = pick_word();
		op.src_value  = pick_word();
		op.flags_in   = 5'($urandom_range(31));
		op.cond_code  = 4'($urandom_range(15));
		return op;
	endfunction

	// Offer one beat, idling first now and then; log its expectation on acceptance.
	task automatic offer_op(input op_t op, input res_t want);
		while (!calm && $urandom_range(99) < 6) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, op.cond_code, op.flags_in, op.src_value, op.dest_value};
		s_axis_tuser  <= {op.size, op.mode};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_results.push_back(want);
		accepted_ops++;
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: take the typed expectation where one is given.
		for (int i = 0; i < OPENING_N; i++) begin
			next_op.mode       = opening_ops[i].mode;
			next_op.size       = opening_ops[i].size;
			next_op.dest_value = opening_ops[i].dest;
			next_op.src_value  = opening_ops[i].src;
			next_op.flags_in   = opening_ops[i].fl;
			next_op.cond_code  = opening_ops[i].cc;
			if (opening_ops[i].known) begin
				row_beat.result       = opening_ops[i].x_res;
				row_beat.flags_out    = opening_ops[i].x_fl;
				row_beat.cond_true    = opening_ops[i].x_ct;
				row_beat.branch_taken = opening_ops[i].x_tk;
			end else begin
				row_beat = alu_outcome(next_op);
			end
			offer_op(next_op, row_beat);
		end

		// Random beats, with a quiet stretch where neither side idles.
		for (int i = 0; i < RANDOM_OPS; i++) begin
			calm <= (i >= CALM_FIRST) && (i < CALM_LAST);
			next_op = random_op();
			offer_op(next_op, alu_outcome(next_op));
		end
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Hold off the output once for a long stretch so both stages fill and
	// s_axis_tready drops while the sender keeps offering.
	initial begin
		wait (accepted_ops >= HOLD_AFTER);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen_beat.result       = m_axis_tdata[31:0];
				seen_beat.flags_out    = m_axis_tdata[36:32];
				seen_beat.cond_true    = m_axis_tdata[37];
				seen_beat.branch_taken = m_axis_tdata[38];
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected: %h", m_axis_tdata);
					fail_count++;
				end else begin
					due_beat = pending_results.pop_front();
					if (seen_beat.result !== due_beat.result) begin
						$error("result: expected %h, got %h",
							due_beat.result, seen_beat.result);
						fail_count++;
					end
					if (seen_beat.flags_out !== due_beat.flags_out) begin
						$error("flags_out: expected %h, got %h",
							due_beat.flags_out, seen_beat.flags_out);
						fail_count++;
					end
					if (seen_beat.cond_true !== due_beat.cond_true) begin
						$error("cond_true: expected %b, got %b",
							due_beat.cond_true, seen_beat.cond_true);
						fail_count++;
					end
					if (seen_beat.branch_taken !== due_beat.branch_taken) begin
						$error("branch_taken: expected %b, got %b",
							due_beat.branch_taken, seen_beat.branch_taken);
						fail_count++;
					end
				end
			end
			m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 6);
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule

[cpu_alu_condition_code_unit.f]
rtl/acu_pkg.sv
rtl/cpu_alu_condition_code_unit.sv
sim/cpu_alu_condition_code_unit_tb.sv
